/* rtl/line_command_pwm_setter_core_assert.svh */
// Assertion macros for the line command PWM setter core.
// Used by modules that have clk and arst_n in scope; no other dependencies.
`ifndef LINE_COMMAND_PWM_SETTER_CORE_ASSERT_SVH
`define LINE_COMMAND_PWM_SETTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcps assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define LCPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcps assertion failed (next cycle)");

`endif

/* rtl/lcps_pkg.sv */
// Shared constants, types and helper functions for the line command PWM setter.
// Used by lcps_ctrl, lcps_datapath and line_command_pwm_setter_core.
`timescale 1ns / 1ps

package lcps_pkg;

	// Line store geometry.
	localparam int LINE_BYTES = 15;
	localparam int POS_W      = $clog2(LINE_BYTES);

	// Character codes.
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_F       = 8'h46;

	// Prescaler division: timer clock over frequency, one quotient bit per cycle.
	localparam int              DIV_W     = 23;
	localparam logic [DIV_W-1:0] CLOCK_NUM = 23'd7200000;
	localparam int              CNT_W     = $clog2(DIV_W);

	// Reciprocal of ten in 16 fractional bits, exact for values below 16384.
	localparam logic [12:0] RECIP_TEN = 13'd6554;

	// Result word width: kind, duty, freq, compare, prescaler, saturated flag.
	localparam int OUT_W = 56;

	// Command kinds.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DUTY = 2'd1;
	localparam logic [1:0] KIND_FREQ = 2'd2;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PARSE,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take_byte;
		logic parse;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic rx_newline;
	} status_t;

	// Digit value of a stored byte, wrapping modulo 256.
	function automatic logic [7:0] digit(input logic [7:0] b);
		return b - CH_ZERO;
	endfunction

endpackage

/* rtl/lcps_datapath.sv */
// Datapath of the line command PWM setter: line store, duty and frequency
// registers, iterative prescaler divider and the result register. Uses lcps_pkg.
`timescale 1ns / 1ps

module lcps_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 rx_byte,
	input  lcps_pkg::cmd_t             cmd,
	output lcps_pkg::status_t          status,
	output logic [lcps_pkg::OUT_W-1:0] out_data
);

	logic [7:0]                       store_q [lcps_pkg::LINE_BYTES];
	logic [lcps_pkg::POS_W-1:0]       pos_q;
	logic [11:0]                      duty_q;
	logic [15:0]                      freq_q;
	logic [1:0]                       kind_q;
	logic [15:0]                      rem_q;
	logic [lcps_pkg::DIV_W-1:0]       quo_q;
	logic [lcps_pkg::OUT_W-1:0]       out_q;

	logic                             is_newline;
	logic [7:0]                       d2, d3, d4, d5;
	logic [11:0]                      duty_next;
	logic [18:0]                      freq_sum;
	logic [16:0]                      rem_sh;
	logic                             rem_ge;
	logic [15:0]                      rem_next;
	logic [lcps_pkg::DIV_W-1:0]       quo_m1;
	logic                             sat;
	logic [15:0]                      presc;
	logic [24:0]                      cmp_prod;

	assign is_newline        = (rx_byte == lcps_pkg::CH_NEWLINE);
	assign status.rx_newline = is_newline;

	// Line store and write position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lcps_pkg::LINE_BYTES; i++) begin
				store_q[i] <= 8'h00;
			end
			pos_q <= '0;
		end else if (cmd.take_byte) begin
			if (is_newline) begin
				store_q[pos_q] <= 8'h00;
				pos_q          <= '0;
			end else if (pos_q < lcps_pkg::POS_W'(lcps_pkg::LINE_BYTES - 1)) begin
				store_q[pos_q] <= rx_byte;
				pos_q          <= pos_q + lcps_pkg::POS_W'(1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	// Command decoding from fixed line positions.
	always_comb begin
		d2        = lcps_pkg::digit(store_q[2]);
		d3        = lcps_pkg::digit(store_q[3]);
		d4        = lcps_pkg::digit(store_q[4]);
		d5        = lcps_pkg::digit(store_q[5]);
		duty_next = 12'(d4) * 12'd10 + 12'(d5);
		freq_sum  = 19'(d2) * 19'd1000 + 19'(d3) * 19'd100 + 19'(d4) * 19'd10 + 19'(d5);
	end

	// Stored duty and frequency numbers and the command kind of the last line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			freq_q <= '0;
			kind_q <= lcps_pkg::KIND_NONE;
		end else if (cmd.parse) begin
			if (store_q[0] == lcps_pkg::CH_P) begin
				duty_q <= duty_next;
				kind_q <= lcps_pkg::KIND_DUTY;
			end else if (store_q[0] == lcps_pkg::CH_F) begin
				freq_q <= freq_sum[15:0];
				kind_q <= lcps_pkg::KIND_FREQ;
			end else begin
				kind_q <= lcps_pkg::KIND_NONE;
			end
		end
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, quo_q[lcps_pkg::DIV_W-1]};
		rem_ge   = (rem_sh >= {1'b0, freq_q});
		rem_next = rem_ge ? 16'(rem_sh - {1'b0, freq_q}) : rem_sh[15:0];
	end

	// Divider registers; the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (cmd.parse) begin
			rem_q <= '0;
			quo_q <= lcps_pkg::CLOCK_NUM;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[lcps_pkg::DIV_W-2:0], rem_ge};
		end
	end

	// Prescaler saturation and value from the divider quotient, compare value from the stored duty.
	always_comb begin
		quo_m1   = quo_q - lcps_pkg::DIV_W'(1);
		sat      = (freq_q == 16'd0) || (quo_m1[lcps_pkg::DIV_W-1:16] != '0);
		presc    = sat ? 16'hFFFF : quo_m1[15:0];
		cmp_prod = 25'(duty_q) * 25'(lcps_pkg::RECIP_TEN);
	end

	// Result register, held until the receiver takes it.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {sat, presc, cmp_prod[24:16], freq_q, duty_q, kind_q};
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/lcps_ctrl.sv */
// Controller of the line command PWM setter: input and output handshakes and
// sequencing of parse, divide and result load. Uses lcps_pkg and the assert macros.
`timescale 1ns / 1ps
`include "line_command_pwm_setter_core_assert.svh"

module lcps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lcps_pkg::status_t status,
	output lcps_pkg::cmd_t    cmd
);

	lcps_pkg::state_t           state_q, state_d;
	logic [lcps_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                       out_valid_q, out_valid_d;
	logic                       div_last;

	// The divider is on its last step.
	assign div_last = (cnt_q == lcps_pkg::CNT_W'(lcps_pkg::DIV_W - 1));

	// State, step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcps_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			lcps_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_byte = in_valid;
				if (in_valid && status.rx_newline) begin
					state_d = lcps_pkg::ST_PARSE;
				end
			end
			lcps_pkg::ST_PARSE: begin
				cmd.parse = 1'b1;
				cnt_d     = '0;
				state_d   = lcps_pkg::ST_DIV;
			end
			lcps_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + lcps_pkg::CNT_W'(1);
				if (div_last) begin
					state_d = lcps_pkg::ST_DONE;
				end
			end
			lcps_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = lcps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcps_pkg::ST_IDLE;
			end
		endcase
	end

	// A loaded result stays valid until the transaction completes.
	always_comb begin
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	// A result is never loaded over one that has not been taken.
	`LCPS_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_q || out_ready)
	// Input is taken only while no line is being processed.
	`LCPS_ASSERT_NOW(a_ready_idle, in_ready, state_q == lcps_pkg::ST_IDLE)
	// An accepted newline starts the parse step.
	`LCPS_ASSERT_NEXT(a_nl_parse, cmd.take_byte && status.rx_newline, state_q == lcps_pkg::ST_PARSE)
	// The last division step leads to the result load.
	`LCPS_ASSERT_NEXT(a_div_end, cmd.div_step && div_last, state_q == lcps_pkg::ST_DONE)
	// A result load always makes the output valid.
	`LCPS_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_q)

endmodule

/* rtl/line_command_pwm_setter_core.sv */
// Top level of the line command PWM setter; joins lcps_ctrl and lcps_datapath.
// Depends on lcps_pkg.
//
// Usage:
//   The slave channel takes one received serial byte per transaction. Bytes
//   collect in a 15-byte line store; a newline (0x0A) ends the line, which is
//   parsed by its first byte ('P' sets duty, 'F' sets frequency).
//   The master channel gives one result per newline: command kind, stored duty
//   and frequency, compare value (duty / 10) and the timer prescaler
//   (7200000 / frequency - 1, saturated, with a flag).
// Sequencing:
//   An ordinary byte is accepted in the idle state; the next byte can follow at once.
//   A newline is taken, the line is parsed, the prescaler divider runs one quotient
//   bit per cycle and the result register is loaded; input is not accepted during
//   those steps.
// Reset and stall:
//   Reset clears the line store, the write position, duty and frequency.
//   A waiting result holds in the output register while bytes keep being
//   accepted; the next newline waits at its load step until it is taken.
`timescale 1ns / 1ps

module line_command_pwm_setter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // rx_byte[7:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// command_kind[1:0], duty_value[13:2], freq_value[29:14], compare_value[38:30],
	// prescaler_value[54:39], prescaler_saturated[55]
	output logic [lcps_pkg::OUT_W-1:0] m_tdata
);

	lcps_pkg::cmd_t    cmd;
	lcps_pkg::status_t status;

	lcps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lcps_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_tdata)
	);

endmodule

/* sim/line_command_pwm_setter_core_test.sv */
// Self-checking testbench for line_command_pwm_setter_core.
// Drives serial bytes on the slave stream, predicts every newline result and checks
// the master stream against it. Depends on lcps_pkg and the core RTL.
`timescale 1ns / 1ps

module line_command_pwm_setter_core_test;

	localparam int unsigned TIMER_CLOCK_HZ = 7200000;
	localparam int          DRAIN_CYCLES   = 40;
	localparam int          PHASE_BYTES    = 370;

	typedef struct {
		logic [1:0]  kind;
		logic [11:0] duty;
		logic [15:0] freq;
		logic [8:0]  compare;
		logic [15:0] prescaler;
		logic        saturated;
	} pwm_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [7:0]                   s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [lcps_pkg::OUT_W-1:0]   m_tdata;

	// Predicted copy of the block state.
	logic [7:0]          line_copy [lcps_pkg::LINE_BYTES];
	int unsigned         line_pos;
	logic [11:0]         duty_num;
	logic [15:0]         freq_num;
	pwm_result_t         pending_results [$];

	int unsigned         error_count;
	int unsigned         bytes_sent;
	int unsigned         send_idle_pct;
	int unsigned         recv_stall_pct;
	int unsigned         hold_off_cycles;

	line_command_pwm_setter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Digit value of a stored byte, wrapping modulo 256.
	function automatic int unsigned stored_digit(input int idx);
		logic [7:0] d;
		d = line_copy[idx] - lcps_pkg::CH_ZERO;
		return d;
	endfunction

	// Update the predicted state for one accepted byte; a newline queues a result.
	task automatic predict_byte(input logic [7:0] b);
		pwm_result_t r;
		int unsigned sum;
		int unsigned quot;
		if (b != lcps_pkg::CH_NEWLINE) begin
			if (line_pos < lcps_pkg::LINE_BYTES - 1) begin
				line_copy[line_pos] = b;
				line_pos++;
			end else begin
				line_pos = 0;
			end
		end else begin
			line_copy[line_pos] = 8'h00;
			line_pos = 0;
			r.kind = lcps_pkg::KIND_NONE;
			if (line_copy[0] == lcps_pkg::CH_P) begin
				sum = 10 * stored_digit(4) + stored_digit(5);
				duty_num = sum[11:0];
				r.kind = lcps_pkg::KIND_DUTY;
			end else if (line_copy[0] == lcps_pkg::CH_F) begin
				sum = 1000 * stored_digit(2) + 100 * stored_digit(3)
					+ 10 * stored_digit(4) + stored_digit(5);
				freq_num = sum[15:0];
				r.kind = lcps_pkg::KIND_FREQ;
			end
			// Zero frequency and quotients above 16 bits both clamp.
			if (freq_num == 16'd0) begin
				r.prescaler = 16'hFFFF;
				r.saturated = 1'b1;
			end else begin
				quot = TIMER_CLOCK_HZ / freq_num - 1;
				r.saturated = (quot > 32'hFFFF);
				r.prescaler = r.saturated ? 16'hFFFF : quot[15:0];
			end
			r.duty    = duty_num;
			r.freq    = freq_num;
			r.compare = 9'(duty_num / 10);
			pending_results.push_back(r);
		end
	endtask

	// Offer one byte, with a random gap before it, until the transaction completes.
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Stop offering and hold until every predicted result has come back.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [7:0] random_line_byte();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 85)
			return lcps_pkg::CH_ZERO + 8'($urandom_range(0, 9));
		do b = 8'($urandom_range(0, 255)); while (b == lcps_pkg::CH_NEWLINE);
		return b;
	endfunction

	// Mostly well-formed command lines, some short lines that reuse stale bytes,
	// and some raw noise that may hold newlines anywhere.
	task automatic send_random_line();
		int unsigned form;
		int unsigned extra;
		int          i;
		form = $urandom_range(0, 99);
		if (form < 75) begin
			send_byte($urandom_range(0, 1) ? lcps_pkg::CH_P : lcps_pkg::CH_F);
			for (i = 1; i < 6; i++)
				send_byte(random_line_byte());
			extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : 0;
			repeat (extra) send_byte(random_line_byte());
			send_byte(lcps_pkg::CH_NEWLINE);
		end else if (form < 88) begin
			case ($urandom_range(0, 2))
				0: send_byte(lcps_pkg::CH_P);
				1: send_byte(lcps_pkg::CH_F);
				default: send_byte(random_line_byte());
			endcase
			repeat ($urandom_range(0, 3)) send_byte(random_line_byte());
			send_byte(lcps_pkg::CH_NEWLINE);
		end else begin
			repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin : receiver
		int unsigned count;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				count = hold_off_cycles;
				hold_off_cycles = 0;
				m_tready <= 1'b0;
				repeat (count) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Compare every result transaction with the oldest prediction.
	always @(posedge clk) begin : result_check
		pwm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, expected nothing actual %h",
					$time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("command_kind", want.kind, m_tdata[1:0]);
				compare_field("duty_value", want.duty, m_tdata[13:2]);
				compare_field("freq_value", want.freq, m_tdata[29:14]);
				compare_field("compare_value", want.compare, m_tdata[38:30]);
				compare_field("prescaler_value", want.prescaler, m_tdata[54:39]);
				compare_field("prescaler_saturated", want.saturated, m_tdata[55]);
			end
		end
	end

	// A newline right after reset parses a cleared store.
	task automatic test_reset_line();
		send_text("\n");
	endtask

	// Duty from the largest non-digit values and from plain zeros.
	task automatic test_duty_extremes();
		send_text("P   //\n");
		send_text("P   00\n");
	endtask

	// Frequency from stale non-digit bytes, zero, both sides of the
	// saturation boundary and the largest decimal value.
	task automatic test_freq_commands();
		send_text("F\n");
		send_text("F 0000\n");
		send_text("F 0109\n");
		send_text("F 0110\n");
		send_text("F 9999\n");
	endtask

	// A newline in the last slot, then a full store whose extra byte is dropped.
	task automatic test_line_store_limits();
		send_text("F 0001abcdefgh\n");
		send_text("P   12abcdefghQ\n");
	endtask

	// A short line reuses bytes left from earlier lines; an unknown first byte.
	task automatic test_stale_bytes();
		send_text("P\n");
		send_text("X\n");
		wait_results_drained();
	endtask

	task automatic test_random_lines(input int unsigned idle_pct,
		input int unsigned stall_pct);
		int unsigned stop_at;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = bytes_sent + PHASE_BYTES;
		while (bytes_sent < stop_at)
			send_random_line();
		wait_results_drained();
	endtask

	// Long receiver hold-off while lines keep coming, so the input stalls.
	task automatic test_output_backpressure();
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 300;
		repeat (8) send_text("P   37\n");
		wait_results_drained();
	endtask

	initial begin : stimulus
		int i;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		for (i = 0; i < lcps_pkg::LINE_BYTES; i++)
			line_copy[i] = 8'h00;
		line_pos        = 0;
		duty_num        = '0;
		freq_num        = '0;
		error_count     = 0;
		bytes_sent      = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_line();
		test_duty_extremes();
		test_freq_commands();
		test_line_store_limits();
		test_stale_bytes();
		test_random_lines(0, 0);
		test_random_lines(64, 0);
		test_random_lines(0, 64);
		test_random_lines(28, 28);
		test_output_backpressure();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
